// ===== hw/rtl/graph_component_cost_core_defines.svh =====
// assertion macros for the graph component cost core checker
// no dependencies; included by the checker file
`ifndef GRAPH_COMPONENT_COST_CORE_DEFINES_SVH
`define GRAPH_COMPONENT_COST_CORE_DEFINES_SVH

// antecedent holds, consequent must hold in the next cycle
`define GCOST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// antecedent holds, consequent must hold in the same cycle
`define GCOST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gcost_pkg.sv =====
// shared types and constants for the graph component cost core
// no dependencies
package gcost_pkg;

    // fixed field widths
    localparam int COUNT_W     = 11;
    localparam int COST_W      = 20;
    localparam int TOTAL_W     = 30;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIBRARY_COST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROAD_COST    = 2'd2;

    // command carried in the input tuser
    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic clr;
    } t_mac_ctl;

endpackage

// ===== hw/rtl/gcost_table.sv =====
// parent table memory: one write port, one registered read port
// no dependencies
module gcost_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rdata
);

    logic [AW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gcost_cost_unit.sv =====
// shared multiply-accumulate unit for the cost sum
// depends on gcost_pkg
module gcost_cost_unit
    import gcost_pkg::*;
#(
    parameter int CNT_W = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctl           i_ctl,
    input  logic [CNT_W-1:0]   i_cnt,
    input  logic [COST_W-1:0]  i_cost,
    output logic [TOTAL_W-1:0] o_acc
);

    localparam int PROD_W = CNT_W + COST_W;

    logic [PROD_W-1:0]  r_prod;
    logic               r_pv;
    logic               r_pclr;
    logic [TOTAL_W-1:0] r_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_pclr <= 1'b0;
        end else begin
            r_pv   <= i_ctl.issue;
            r_pclr <= i_ctl.clr;
        end
        r_prod <= PROD_W'(i_cnt) * PROD_W'(i_cost);
    end

    // accumulate stage, wraps modulo the result width
    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc <= (r_pclr ? '0 : r_acc) + TOTAL_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/graph_component_cost_core.sv =====
// graph component cost core: union-find sequencer over the parent table
// depends on gcost_pkg, gcost_table, gcost_cost_unit
//
// channel   dir  beat contents
// s_axis    in   tuser: cmd; tdata: city_a [10:0], city_b [21:11]
// m_axis    out  tdata: total_cost [29:0], components [40:30]
// cfg       in   we, idx, data: node_count, library_cost, road_cost
//
// edge: accept, then both finds check each node (check and halve per parent hop)
// edge naming a node out of range: dropped on accept
// finish: accept, two multiply issues, drain and load, then a clear that
//   restores each live node in turn; a node_count write also starts it
// the load waits while an earlier result stalls on the output; input is
//   held off meanwhile; reset runs a clear of the single live node, input held off
module graph_component_cost_core
    import gcost_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // city_a, city_b
    input  logic                   i_s_axis_tuser,   // cmd
    // result beats
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // total_cost, components
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COST_W-1:0]      i_cfg_data
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_CHK1, S_CHK2, S_MUL1, S_MUL2, S_MWAIT, S_LOAD
    } t_state;

    // clamp a written node count into 1..MAX_NODES
    function automatic logic [NW-1:0] live_n(input logic [COUNT_W-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext == '0) begin
            ext = CW'(1);
        end else if (ext > CW'(MAX_NODES)) begin
            ext = CW'(MAX_NODES);
        end
        return NW'(ext);
    endfunction

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_node_count, n_node_count;
    logic [COST_W-1:0]    r_lib, n_lib;
    logic [COST_W-1:0]    r_road, n_road;
    logic [NW-1:0]        r_gc, n_gc;
    logic [IW-1:0]        r_x, n_x;
    logic [IW-1:0]        r_b, n_b;
    logic [IW-1:0]        r_ra, n_ra;
    logic                 r_phase, n_phase;
    logic [IW-1:0]        r_clr_idx, n_clr_idx;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [NW-1:0]        w_n;
    logic [NW-1:0]        w_c;
    logic                 w_lib_le;
    logic                 w_accept;
    logic [COUNT_W-1:0]   w_city_a, w_city_b;
    logic [CW-1:0]        w_a_ext, w_b_ext;
    logic                 w_in_range;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr, mem_wdata, mem_raddr, mem_rdata;
    t_mac_ctl             mac_ctl;
    logic [NW-1:0]        mac_cnt;
    logic [COST_W-1:0]    mac_cost;
    logic [TOTAL_W-1:0]   mac_acc;

    gcost_table #(
        .DEPTH (MAX_NODES),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    gcost_cost_unit #(
        .CNT_W (NW)
    ) u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_cnt   (mac_cnt),
        .i_cost  (mac_cost),
        .o_acc   (mac_acc)
    );

    // live node count and clamped component count
    assign w_n      = live_n(r_node_count);
    assign w_c      = (r_gc > w_n) ? w_n : ((r_gc == '0) ? NW'(1) : r_gc);
    assign w_lib_le = (r_lib <= r_road);

    // input beat decode and endpoint range check
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_city_a   = i_s_axis_tdata[COUNT_W-1:0];
    assign w_city_b   = i_s_axis_tdata[2*COUNT_W-1:COUNT_W];
    assign w_a_ext    = CW'(w_city_a);
    assign w_b_ext    = CW'(w_city_b);
    assign w_in_range = (w_a_ext != '0) && (w_a_ext <= CW'(w_n)) &&
                        (w_b_ext != '0) && (w_b_ext <= CW'(w_n));

    // sequencer next state, table access and multiplier issue
    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_lib        = r_lib;
        n_road       = r_road;
        n_gc         = r_gc;
        n_x          = r_x;
        n_b          = r_b;
        n_ra         = r_ra;
        n_phase      = r_phase;
        n_clr_idx    = r_clr_idx;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        mem_we       = 1'b0;
        mem_waddr    = r_x;
        mem_wdata    = mem_rdata;
        mem_raddr    = r_x;
        mac_ctl      = '0;
        mac_cnt      = '0;
        mac_cost     = r_lib;

        // result beat taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                // restore identity over the live nodes
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = r_clr_idx;
                if (r_clr_idx == IW'(w_n - NW'(1))) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + IW'(1);
                end
            end
            S_IDLE: begin
                mem_raddr = IW'(w_a_ext - CW'(1));
                if (w_accept) begin
                    if (i_s_axis_tuser == CMD_FINISH) begin
                        n_state = S_MUL1;
                    end else if (w_in_range) begin
                        n_x     = IW'(w_a_ext - CW'(1));
                        n_b     = IW'(w_b_ext - CW'(1));
                        n_phase = 1'b0;
                        n_state = S_CHK1;
                    end
                end
            end
            S_CHK1: begin
                // read data is the parent of r_x
                if (mem_rdata == r_x) begin
                    if (!r_phase) begin
                        n_ra      = r_x;
                        n_x       = r_b;
                        n_phase   = 1'b1;
                        mem_raddr = r_b;
                    end else begin
                        if (r_ra != r_x) begin
                            mem_we = 1'b1;
                            if (r_ra < r_x) begin
                                mem_waddr = r_x;
                                mem_wdata = r_ra;
                            end else begin
                                mem_waddr = r_ra;
                                mem_wdata = r_x;
                            end
                            if (r_gc > NW'(1)) begin
                                n_gc = r_gc - NW'(1);
                            end
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    mem_raddr = mem_rdata;
                    n_state   = S_CHK2;
                end
            end
            S_CHK2: begin
                // read data is the grandparent: halve the path
                mem_we    = 1'b1;
                mem_waddr = r_x;
                mem_wdata = mem_rdata;
                mem_raddr = mem_rdata;
                n_x       = mem_rdata;
                n_state   = S_CHK1;
            end
            S_MUL1: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.clr   = 1'b1;
                mac_cnt       = w_lib_le ? w_n : w_c;
                mac_cost      = r_lib;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                mac_ctl.issue = 1'b1;
                mac_cnt       = w_lib_le ? '0 : (w_n - w_c);
                mac_cost      = r_road;
                n_state       = S_MWAIT;
            end
            S_MWAIT: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // park here until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({COUNT_W'(w_c), mac_acc});
                    n_gc        = w_n;
                    n_clr_idx   = '0;
                    n_state     = S_CLR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_COUNT: begin
                    n_node_count = i_cfg_data[COUNT_W-1:0];
                    n_gc         = live_n(i_cfg_data[COUNT_W-1:0]);
                    n_clr_idx    = '0;
                    n_state      = S_CLR;
                end
                CFG_LIBRARY_COST: n_lib  = i_cfg_data;
                CFG_ROAD_COST:    n_road = i_cfg_data;
                default: ;
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_node_count <= COUNT_W'(1);
            r_lib        <= '0;
            r_road       <= '0;
            r_gc         <= NW'(1);
            r_clr_idx    <= '0;
            r_phase      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_lib        <= n_lib;
            r_road       <= n_road;
            r_gc         <= n_gc;
            r_clr_idx    <= n_clr_idx;
            r_phase      <= n_phase;
            r_out_valid  <= n_out_valid;
        end
        r_x        <= n_x;
        r_b        <= n_b;
        r_ra       <= n_ra;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/gcost_checker.sv =====
// port-level checker for the graph component cost core, with its bind
// depends on gcost_pkg and graph_component_cost_core_defines.svh
`include "graph_component_cost_core_defines.svh"

module gcost_checker
    import gcost_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   i_cfg_we,
    input logic [CFG_IDX_W-1:0]   i_cfg_idx
);

    // a stalled result beat holds
    `GCOST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat changed while stalled")

    // a result always reports at least one component
    `GCOST_ASSERT_SAME(a_comp_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[TOTAL_W+COUNT_W-1:TOTAL_W] != '0, "result with zero components")

    // a finish beat holds off input while the cost is formed
    `GCOST_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_FINISH), !o_s_axis_tready, "input ready right after a finish beat")

    // a node count write starts a table clear
    `GCOST_ASSERT_NEXT(a_cfg_clear, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == CFG_NODE_COUNT), !o_s_axis_tready, "input ready right after a node count write")

endmodule

bind graph_component_cost_core gcost_checker u_gcost_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_idx       (i_cfg_idx)
);
